// File: src/mnmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mailbox package
// Shared field widths, action and status codes, defaults and the result
// control bundle used between the queue controller and the top level.
// ----------------------------------------------------------------------------
package mnmb_pkg;

   localparam int DEF_NODES         = 4;
   localparam int DEF_SLOTS_PER_BOX = 16;
   localparam int DEF_PAYLOAD_BYTES = 8;

   localparam int ACTION_W  = 2;
   localparam int NODE_F_W  = 3;
   localparam int SOURCE_W  = 8;
   localparam int LENGTH_W  = 4;
   localparam int PAYLOAD_W = 64;
   localparam int STATUS_W  = 3;
   localparam int NOTIFY_W  = 8;
   localparam int SLOTS_W   = 5;

   localparam logic [SLOTS_W-1:0] SLOTS_RESET = 5'd16;

   localparam logic [ACTION_W-1:0] ACT_SEND  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_RECV  = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_NODE = 3'd1;
   localparam logic [STATUS_W-1:0] ST_BAD_LEN  = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_SLOTS = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd5;

   typedef struct packed {
      logic                valid;
      logic                got_msg;
      logic [STATUS_W-1:0] status;
      logic [NOTIFY_W-1:0] notify;
   } rsp_ctl_type;

   // Keep the first len bytes of a packed payload.
   function automatic logic [PAYLOAD_W-1:0] byte_mask(input logic [LENGTH_W-1:0] len);
      logic [PAYLOAD_W-1:0] m;
      m = '0;
      for (int b = 0; b < PAYLOAD_W / 8; b++) begin
         if (b < int'(len)) begin
            m[b*8 +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage
`default_nettype wire

// File: src/mnmb_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mailbox register port
// Holds the slot count register behind an APB-style port.
// ----------------------------------------------------------------------------
module mnmb_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [1:0]                  paddr,
   input  wire logic [31:0]                 pwdata,
   output logic      [31:0]                 prdata,
   output logic                             pready,
   output logic      [mnmb_pkg::SLOTS_W-1:0] slots_in_use
);
   import mnmb_pkg::*;

   logic [SLOTS_W-1:0] slots_ff;
   logic [SLOTS_W-1:0] slots_in;
   logic               wr_en;

   // One register: every word address decodes to it.
   assign wr_en = psel & penable & pwrite & pready & (paddr == paddr);

   always_comb begin
      slots_in = slots_ff;
      if (wr_en) begin
         slots_in = pwdata[SLOTS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= SLOTS_RESET;
      end else begin
         slots_ff <= slots_in;
      end
   end

   assign pready       = 1'b1;
   assign prdata       = {{(32 - SLOTS_W){1'b0}}, slots_ff};
   assign slots_in_use = slots_ff;

endmodule
`default_nettype wire

// File: src/mnmb_slot_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mailbox slot memory
// Single-port slot store with registered read data.
// ----------------------------------------------------------------------------
module mnmb_slot_mem #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6,
   parameter int DATA_W = 76
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [DATA_W-1:0] wdata,
   output logic      [DATA_W-1:0] rdata
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// File: src/mnmb_queue_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mailbox queue controller
// Checks each action against the per-node head, tail and fill count,
// steers the slot memory and keeps the notification byte.
// ----------------------------------------------------------------------------
module mnmb_queue_ctrl #(
   parameter int NODES         = 4,
   parameter int SLOTS_PER_BOX = 16,
   parameter int PAYLOAD_BYTES = 8,
   parameter int ADDR_W        = 6
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          valid,
   input  wire logic [mnmb_pkg::ACTION_W-1:0] action,
   input  wire logic [mnmb_pkg::NODE_F_W-1:0] node,
   input  wire logic [mnmb_pkg::LENGTH_W-1:0] length,
   input  wire logic [mnmb_pkg::SLOTS_W-1:0]  slots_in_use,
   output logic                               mem_we,
   output logic                               mem_re,
   output logic      [ADDR_W-1:0]             mem_addr,
   output mnmb_pkg::rsp_ctl_type              rsp_ctl
);
   import mnmb_pkg::*;

   localparam int IDX_W  = (SLOTS_PER_BOX > 1) ? $clog2(SLOTS_PER_BOX) : 1;
   localparam int CNT_W  = $clog2(SLOTS_PER_BOX + 1);
   localparam int NODE_W = (NODES > 1) ? $clog2(NODES) : 1;

   logic [IDX_W-1:0]    head_ff [NODES];
   logic [IDX_W-1:0]    head_in [NODES];
   logic [IDX_W-1:0]    tail_ff [NODES];
   logic [IDX_W-1:0]    tail_in [NODES];
   logic [CNT_W-1:0]    used_ff [NODES];
   logic [CNT_W-1:0]    used_in [NODES];
   logic [NOTIFY_W-1:0] notify_ff;
   logic [NOTIFY_W-1:0] notify_in;
   rsp_ctl_type         rsp_ff;
   rsp_ctl_type         rsp_in;

   logic [CNT_W-1:0]  eff_count;
   logic [NODE_W-1:0] nidx;
   logic              node_ok;
   logic              len_ok;
   logic [CNT_W-1:0]  used_cur;
   logic [IDX_W-1:0]  sel_idx;
   logic [CNT_W-1:0]  next_idx;
   logic              do_send;
   logic              do_recv;
   logic [STATUS_W-1:0] status;

   // Saturate the programmed count at the physical queue depth.
   assign eff_count = (32'(slots_in_use) > SLOTS_PER_BOX) ? CNT_W'(SLOTS_PER_BOX)
                                                           : CNT_W'(slots_in_use);
   assign nidx     = node[NODE_W-1:0];
   assign node_ok  = (32'(node) < NODES);
   assign len_ok   = (length != '0) && (32'(length) <= PAYLOAD_BYTES);
   assign used_cur = node_ok ? used_ff[nidx] : '0;

   always_comb begin
      status  = ST_OK;
      do_send = 1'b0;
      do_recv = 1'b0;
      case (action)
         ACT_SEND: begin
            if (!node_ok) begin
               status = ST_BAD_NODE;
            end else if (!len_ok) begin
               status = ST_BAD_LEN;
            end else if (eff_count == '0) begin
               status = ST_NO_SLOTS;
            end else if (used_cur >= eff_count) begin
               status = ST_FULL;
            end else begin
               do_send = valid;
            end
         end
         ACT_RECV: begin
            if (!node_ok) begin
               status = ST_BAD_NODE;
            end else if (eff_count == '0) begin
               status = ST_NO_SLOTS;
            end else if (used_cur == '0) begin
               status = ST_EMPTY;
            end else begin
               do_recv = valid;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
   end

   // Slot index of this access and its wrapped successor.
   assign sel_idx  = !node_ok ? '0 : (do_send ? tail_ff[nidx] : head_ff[nidx]);
   assign next_idx = ((CNT_W'(sel_idx) + CNT_W'(1)) >= eff_count) ? '0
                                                                 : (CNT_W'(sel_idx) + CNT_W'(1));

   assign mem_we   = do_send;
   assign mem_re   = do_recv;
   assign mem_addr = ADDR_W'(32'(nidx) * SLOTS_PER_BOX + 32'(sel_idx));

   always_comb begin
      for (int n = 0; n < NODES; n++) begin
         head_in[n] = head_ff[n];
         tail_in[n] = tail_ff[n];
         used_in[n] = used_ff[n];
      end
      notify_in = notify_ff;
      if (valid && action == ACT_CLEAR) begin
         for (int n = 0; n < NODES; n++) begin
            head_in[n] = '0;
            tail_in[n] = '0;
            used_in[n] = '0;
         end
         notify_in = '0;
      end else if (do_send) begin
         tail_in[nidx] = IDX_W'(next_idx);
         used_in[nidx] = used_ff[nidx] + CNT_W'(1);
         notify_in     = notify_ff | (NOTIFY_W'(1) << node);
      end else if (do_recv) begin
         head_in[nidx] = IDX_W'(next_idx);
         used_in[nidx] = used_ff[nidx] - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in.valid   = valid;
      rsp_in.got_msg = do_recv;
      rsp_in.status  = status;
      rsp_in.notify  = notify_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < NODES; n++) begin
            head_ff[n] <= '0;
            tail_ff[n] <= '0;
            used_ff[n] <= '0;
         end
         notify_ff <= '0;
         rsp_ff    <= '0;
      end else begin
         for (int n = 0; n < NODES; n++) begin
            head_ff[n] <= head_in[n];
            tail_ff[n] <= tail_in[n];
            used_ff[n] <= used_in[n];
         end
         notify_ff <= notify_in;
         rsp_ff    <= rsp_in;
      end
   end

   assign rsp_ctl = rsp_ff;

endmodule
`default_nettype wire

// File: src/multi_node_mailbox_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-node mailbox FIFO
// Results strobe from a result register that follows the input register.
// Throughput: one beat per cycle; busy stays low, and the slot memory port
//   serves the single read or write of each action.
// Reset: synchronous; empties every queue, clears notifications, slot count 16.
// The slot memory is not cleared; the receiver cannot stall results.
// ----------------------------------------------------------------------------
module multi_node_mailbox_fifo #(
   parameter int NODES         = mnmb_pkg::DEF_NODES,
   parameter int SLOTS_PER_BOX = mnmb_pkg::DEF_SLOTS_PER_BOX,
   parameter int PAYLOAD_BYTES = mnmb_pkg::DEF_PAYLOAD_BYTES
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // command channel
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [mnmb_pkg::ACTION_W-1:0]   req_action,
   input  wire logic [mnmb_pkg::NODE_F_W-1:0]   req_node,
   input  wire logic [mnmb_pkg::SOURCE_W-1:0]   req_source,
   input  wire logic [mnmb_pkg::LENGTH_W-1:0]   req_length,
   input  wire logic [mnmb_pkg::PAYLOAD_W-1:0]  req_payload,
   // result channel
   output logic                                 rsp_valid,
   output logic      [mnmb_pkg::STATUS_W-1:0]   rsp_status,
   output logic      [mnmb_pkg::SOURCE_W-1:0]   rsp_source_out,
   output logic      [mnmb_pkg::LENGTH_W-1:0]   rsp_length_out,
   output logic      [mnmb_pkg::PAYLOAD_W-1:0]  rsp_payload_out,
   output logic      [mnmb_pkg::NOTIFY_W-1:0]   rsp_notify_bits,
   // register port
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [1:0]                      paddr,
   input  wire logic [31:0]                     pwdata,
   output logic      [31:0]                     prdata,
   output logic                                 pready
);
   import mnmb_pkg::*;

   localparam int DEPTH  = NODES * SLOTS_PER_BOX;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PB_W   = 8 * PAYLOAD_BYTES;
   localparam int DATA_W = SOURCE_W + LENGTH_W + PB_W;

   // Input register: one beat per cycle.
   logic                 valid_ff;
   logic                 valid_in;
   logic [ACTION_W-1:0]  action_ff;
   logic [NODE_F_W-1:0]  node_ff;
   logic [SOURCE_W-1:0]  source_ff;
   logic [LENGTH_W-1:0]  length_ff;
   logic [PAYLOAD_W-1:0] payload_ff;

   logic [SLOTS_W-1:0] slots_in_use;
   logic               mem_we;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_addr;
   logic [DATA_W-1:0]  mem_wdata;
   logic [DATA_W-1:0]  mem_rdata;
   logic [PAYLOAD_W-1:0] masked_payload;
   rsp_ctl_type        rsp_ctl;

   // Never hold off a command: every action finishes in one pass.
   assign busy     = 1'b0;
   assign valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload registers load on every accepted beat; no reset needed.
   always_ff @(posedge clock) begin
      if (valid_in) begin
         action_ff  <= req_action;
         node_ff    <= req_node;
         source_ff  <= req_source;
         length_ff  <= req_length;
         payload_ff <= req_payload;
      end
   end

   mnmb_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .slots_in_use (slots_in_use)
   );

   mnmb_queue_ctrl #(
      .NODES         (NODES),
      .SLOTS_PER_BOX (SLOTS_PER_BOX),
      .PAYLOAD_BYTES (PAYLOAD_BYTES),
      .ADDR_W        (ADDR_W)
   ) u_queue_ctrl (
      .clock        (clock),
      .reset        (reset),
      .valid        (valid_ff),
      .action       (action_ff),
      .node         (node_ff),
      .length       (length_ff),
      .slots_in_use (slots_in_use),
      .mem_we       (mem_we),
      .mem_re       (mem_re),
      .mem_addr     (mem_addr),
      .rsp_ctl      (rsp_ctl)
   );

   // Drop payload bytes past the message length before storing the slot.
   assign masked_payload = payload_ff & byte_mask(length_ff);
   assign mem_wdata      = {source_ff, length_ff, masked_payload[PB_W-1:0]};

   mnmb_slot_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (DATA_W)
   ) u_slot_mem (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   // Result beat: message fields only when a receive popped a slot.
   assign rsp_valid       = rsp_ctl.valid;
   assign rsp_status      = rsp_ctl.status;
   assign rsp_notify_bits = rsp_ctl.notify;
   assign rsp_source_out  = rsp_ctl.got_msg ? mem_rdata[DATA_W-1 -: SOURCE_W] : '0;
   assign rsp_length_out  = rsp_ctl.got_msg ? mem_rdata[PB_W +: LENGTH_W] : '0;
   assign rsp_payload_out = rsp_ctl.got_msg ? PAYLOAD_W'(mem_rdata[PB_W-1:0]) : '0;

endmodule
`default_nettype wire

// File: src/mnmb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Mailbox port checker
// Watches the command and result ports of the mailbox over time.
// ----------------------------------------------------------------------------
module mnmb_checker #(
   parameter int NODES = 4
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic [mnmb_pkg::ACTION_W-1:0]  req_action,
   input wire logic [mnmb_pkg::NODE_F_W-1:0]  req_node,
   input wire logic                           rsp_valid,
   input wire logic [mnmb_pkg::STATUS_W-1:0]  rsp_status,
   input wire logic [mnmb_pkg::SOURCE_W-1:0]  rsp_source_out,
   input wire logic [mnmb_pkg::LENGTH_W-1:0]  rsp_length_out,
   input wire logic [mnmb_pkg::PAYLOAD_W-1:0] rsp_payload_out,
   input wire logic [mnmb_pkg::NOTIFY_W-1:0]  rsp_notify_bits
);
   import mnmb_pkg::*;

   // Every result beat answers an earlier command taken on start.
   a_rsp_has_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("result beat without a command");

   // Every command taken outside reset is answered.
   a_cmd_answered: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) ##1 1'b1 |=> rsp_valid)
      else $error("command beat lost");

   // A failed action carries no message.
   a_fail_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_source_out == '0 && rsp_length_out == '0 && rsp_payload_out == '0))
      else $error("message fields set on a failed action");

   // A clear answers ok with no notifications pending.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_action == ACT_CLEAR, 2)) |->
         (rsp_status == ST_OK && rsp_notify_bits == '0))
      else $error("clear left notifications set");

   // A send to a node that does not exist fails as bad node.
   a_bad_node: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_action == ACT_SEND && 32'(req_node) >= NODES, 2)) |->
         (rsp_status == ST_BAD_NODE))
      else $error("send to missing node not refused");

endmodule

bind multi_node_mailbox_fifo mnmb_checker #(
   .NODES (NODES)
) u_mnmb_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_action      (req_action),
   .req_node        (req_node),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_source_out  (rsp_source_out),
   .rsp_length_out  (rsp_length_out),
   .rsp_payload_out (rsp_payload_out),
   .rsp_notify_bits (rsp_notify_bits)
);
`default_nettype wire

// File: tb/sv/multi_node_mailbox_fifo_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mailbox FIFO testbench
// Drives send, receive and clear commands into the per-node mailboxes under
// a range of slot-count settings. A scoreboard class keeps its own copy of
// every queue and predicts each reply, which is checked field by field.
// ----------------------------------------------------------------------------
module multi_node_mailbox_fifo_test;
   import mnmb_pkg::*;

   localparam int MB_NODES      = DEF_NODES;
   localparam int MB_SLOTS      = DEF_SLOTS_PER_BOX;
   localparam int MB_BYTES      = DEF_PAYLOAD_BYTES;
   localparam int MB_SLOT_TOTAL = MB_NODES * MB_SLOTS;
   localparam int RUN_LIMIT     = 400000;

   // The fourth action code does nothing but answer.
   localparam logic [ACTION_W-1:0] ACT_SPARE  = 2'd3;
   // Byte address of the slot-count register.
   localparam logic [1:0]          SLOTS_ADDR = 2'd0;

   typedef struct packed {
      logic [ACTION_W-1:0]  action;
      logic [NODE_F_W-1:0]  node;
      logic [SOURCE_W-1:0]  source;
      logic [LENGTH_W-1:0]  length;
      logic [PAYLOAD_W-1:0] payload;
   } mail_cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [SOURCE_W-1:0]  source;
      logic [LENGTH_W-1:0]  length;
      logic [PAYLOAD_W-1:0] payload;
      logic [NOTIFY_W-1:0]  notify;
   } mail_reply_type;

   // Mask that keeps the low len bytes of a packed payload.
   function automatic logic [PAYLOAD_W-1:0] keep_bytes(int unsigned len);
      if (len == 0) return '0;
      if (len >= PAYLOAD_W / 8) return '1;
      return (64'd1 << (8 * len)) - 64'd1;
   endfunction

   // -------------------------------------------------------------------------
   // Scoreboard: shadow copy of every mailbox plus the replies still owed.
   // -------------------------------------------------------------------------
   class mailbox_ledger;
      logic [SLOTS_W-1:0]   slot_setting;
      int unsigned          head [MB_NODES];
      int unsigned          tail [MB_NODES];
      int unsigned          used [MB_NODES];
      logic [SOURCE_W-1:0]  slot_src [MB_SLOT_TOTAL];
      logic [LENGTH_W-1:0]  slot_len [MB_SLOT_TOTAL];
      logic [PAYLOAD_W-1:0] slot_pay [MB_SLOT_TOTAL];
      bit                   slot_filled [MB_SLOT_TOTAL];
      logic [NOTIFY_W-1:0]  notify;
      mail_reply_type       due_replies [$];
      int                   errors;
      int                   commands;
      int                   delivered;
      int                   refused_full;

      function new();
         slot_setting = SLOTS_RESET;
         notify       = '0;
         errors       = 0;
         commands     = 0;
         delivered    = 0;
         refused_full = 0;
         foreach (head[n]) begin
            head[n] = 0;
            tail[n] = 0;
            used[n] = 0;
         end
         foreach (slot_filled[s]) begin
            slot_src[s]    = '0;
            slot_len[s]    = '0;
            slot_pay[s]    = '0;
            slot_filled[s] = 1'b0;
         end
      endfunction

      // Slot count in force: the setting saturates at the box size.
      function int unsigned depth();
         return (slot_setting > MB_SLOTS) ? MB_SLOTS : slot_setting;
      endfunction

      // True when a receive on node n would pop a slot never written.
      function bit head_unfilled(int unsigned n);
         return used[n] != 0 && !slot_filled[n * MB_SLOTS + head[n] % MB_SLOTS];
      endfunction

      function void post_command(mail_cmd_type c);
         mail_reply_type r;
         int unsigned cnt;
         int unsigned n;
         int unsigned at;
         int unsigned idx;
         r        = '0;
         cnt      = depth();
         n        = c.node;
         commands = commands + 1;
         case (c.action)
            ACT_SEND: begin
               if (n >= MB_NODES) begin
                  r.status = ST_BAD_NODE;
               end else if (c.length == 0 || c.length > MB_BYTES) begin
                  r.status = ST_BAD_LEN;
               end else if (cnt == 0) begin
                  r.status = ST_NO_SLOTS;
               end else if (used[n] >= cnt) begin
                  r.status     = ST_FULL;
                  refused_full = refused_full + 1;
               end else begin
                  at               = tail[n] % MB_SLOTS;
                  idx              = n * MB_SLOTS + at;
                  slot_src[idx]    = c.source;
                  slot_len[idx]    = c.length;
                  slot_pay[idx]    = c.payload & keep_bytes(c.length);
                  slot_filled[idx] = 1'b1;
                  tail[n]          = (at + 1 >= cnt) ? 0 : at + 1;
                  used[n]          = used[n] + 1;
                  notify[n]        = 1'b1;
               end
            end
            ACT_RECV: begin
               if (n >= MB_NODES) begin
                  r.status = ST_BAD_NODE;
               end else if (cnt == 0) begin
                  r.status = ST_NO_SLOTS;
               end else if (used[n] == 0) begin
                  r.status = ST_EMPTY;
               end else begin
                  at       = head[n] % MB_SLOTS;
                  idx      = n * MB_SLOTS + at;
                  r.source = slot_src[idx];
                  r.length = (slot_len[idx] > MB_BYTES) ? '0 : slot_len[idx];
                  r.payload = slot_pay[idx] & keep_bytes(r.length);
                  head[n]   = (at + 1 >= cnt) ? 0 : at + 1;
                  used[n]   = used[n] - 1;
                  delivered = delivered + 1;
               end
            end
            ACT_CLEAR: begin
               foreach (head[k]) begin
                  head[k] = 0;
                  tail[k] = 0;
                  used[k] = 0;
               end
               notify = '0;
            end
            default: ;
         endcase
         r.notify = notify;
         due_replies.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors = errors + 1;
         end
      endfunction

      function void match_reply(mail_reply_type got);
         mail_reply_type want;
         if (due_replies.size() == 0) begin
            $error("reply strobed with no command outstanding");
            errors = errors + 1;
            return;
         end
         want = due_replies.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("source_out", want.source, got.source);
         compare_field("length_out", want.length, got.length);
         compare_field("payload_out", want.payload, got.payload);
         compare_field("notify_bits", want.notify, got.notify);
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block under test and its stimulus signals, all known from time zero.
   // -------------------------------------------------------------------------
   logic                 clock       = 1'b0;
   logic                 reset       = 1'b1;
   logic                 start       = 1'b0;
   logic [ACTION_W-1:0]  req_action  = '0;
   logic [NODE_F_W-1:0]  req_node    = '0;
   logic [SOURCE_W-1:0]  req_source  = '0;
   logic [LENGTH_W-1:0]  req_length  = '0;
   logic [PAYLOAD_W-1:0] req_payload = '0;
   logic                 psel        = 1'b0;
   logic                 penable     = 1'b0;
   logic                 pwrite      = 1'b0;
   logic [1:0]           paddr       = '0;
   logic [31:0]          pwdata      = '0;

   logic                 busy;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [SOURCE_W-1:0]  rsp_source_out;
   logic [LENGTH_W-1:0]  rsp_length_out;
   logic [PAYLOAD_W-1:0] rsp_payload_out;
   logic [NOTIFY_W-1:0]  rsp_notify_bits;
   logic [31:0]          prdata;
   logic                 pready;

   mailbox_ledger ledger;
   int            cycles           = 0;
   int            settings_written = 0;

   multi_node_mailbox_fifo dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_node        (req_node),
      .req_source      (req_source),
      .req_length      (req_length),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_source_out  (rsp_source_out),
      .rsp_length_out  (rsp_length_out),
      .rsp_payload_out (rsp_payload_out),
      .rsp_notify_bits (rsp_notify_bits),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake or a lost reply ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= RUN_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Reply monitor. Outputs read right after the edge still hold the values
   // of the cycle that the edge closes, so each strobe is taken exactly once.
   always @(posedge clock) begin
      mail_reply_type seen;
      if (!reset && rsp_valid === 1'b1) begin
         seen = {rsp_status, rsp_source_out, rsp_length_out, rsp_payload_out,
                 rsp_notify_bits};
         ledger.match_reply(seen);
      end
   end

   // -------------------------------------------------------------------------
   // Drivers
   // -------------------------------------------------------------------------
   function automatic mail_cmd_type mk(logic [ACTION_W-1:0] a, logic [NODE_F_W-1:0] n,
                                       logic [SOURCE_W-1:0] s, logic [LENGTH_W-1:0] l,
                                       logic [PAYLOAD_W-1:0] p);
      mail_cmd_type c;
      c.action  = a;
      c.node    = n;
      c.source  = s;
      c.length  = l;
      c.payload = p;
      return c;
   endfunction

   // Present one command and hold it until the block takes the beat. Start
   // stays high afterward so the next command can follow back to back.
   task automatic issue(input mail_cmd_type c);
      start       <= 1'b1;
      req_action  <= c.action;
      req_node    <= c.node;
      req_source  <= c.source;
      req_length  <= c.length;
      req_payload <= c.payload;
      @(posedge clock);
      while (busy) @(posedge clock);
      ledger.post_command(c);
   endtask

   // Drop start for a number of cycles; zero keeps the stream running.
   task automatic pause(input int n);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // Mostly back to back, some short gaps, a few long ones.
   function automatic int random_gap();
      int r;
      r = $urandom_range(99);
      if (r < 70) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   // Stop issuing, let every owed reply arrive, then write the slot count
   // and read it back.
   task automatic set_slots(input logic [SLOTS_W-1:0] v);
      pause(1);
      while (ledger.due_replies.size() != 0) @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= SLOTS_ADDR;
      pwdata  <= {{(32 - SLOTS_W){1'b0}}, v};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      ledger.slot_setting = v;
      settings_written    = settings_written + 1;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      psel    <= 1'b1;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata[SLOTS_W-1:0] !== v) begin
         $error("slots_in_use readback: expected 0x%0h, got 0x%0h", v, prdata);
         ledger.errors = ledger.errors + 1;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Mostly well-formed sends and receives on real nodes; the rest is noise:
   // bad nodes, bad lengths, the spare action and the odd clear.
   function automatic mail_cmd_type random_command(input int send_pct);
      mail_cmd_type c;
      int           r;
      c.source  = SOURCE_W'($urandom);
      c.payload = {$urandom, $urandom};
      r         = $urandom_range(99);
      if (r < 5) begin
         c.action = ACTION_W'($urandom_range(3));
         c.node   = NODE_F_W'($urandom_range(7));
         c.length = LENGTH_W'($urandom_range(15));
      end else if (r < 7) begin
         c.action = ACT_CLEAR;
         c.node   = NODE_F_W'($urandom_range(7));
         c.length = LENGTH_W'($urandom_range(15));
      end else begin
         c.node   = (r < 12) ? NODE_F_W'($urandom_range(7))
                             : NODE_F_W'($urandom_range(MB_NODES - 1));
         c.length = (r >= 12 && r < 15) ? LENGTH_W'($urandom_range(15))
                                        : LENGTH_W'($urandom_range(MB_BYTES, 1));
         c.action = ($urandom_range(99) < send_pct) ? ACT_SEND : ACT_RECV;
      end
      // A shrunk slot count can leave a head on a slot that was never
      // written; never pop it, flush the queues instead.
      if (c.action == ACT_RECV && c.node < MB_NODES && ledger.depth() != 0 &&
          ledger.head_unfilled(c.node)) begin
         c.action = ACT_CLEAR;
      end
      return c;
   endfunction

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------
   initial begin
      int unsigned phase_slots [10];
      int          phase_items [10];
      int          send_pct;
      bit          calm;
      logic [PAYLOAD_W-1:0] ones;

      phase_slots = '{16, 2, 31, 0, 1, 9, 16, 5, 17, 12};
      phase_items = '{170, 140, 150, 30, 110, 150, 140, 130, 140, 140};
      ones        = '1;
      ledger      = new();

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Edge cases at the reset slot count: empty box, bad node and length
      // refusals, shortest and longest payloads, the spare action, and a
      // clear that wipes a waiting message and the notification byte.
      issue(mk(ACT_RECV, 3'd0, 8'h00, 4'd1, '0));
      issue(mk(ACT_SEND, 3'd4, 8'h11, 4'd1, ones));
      issue(mk(ACT_SEND, 3'd0, 8'h22, 4'd0, ones));
      issue(mk(ACT_SEND, 3'd0, 8'h33, 4'd9, ones));
      issue(mk(ACT_SEND, 3'd0, 8'h44, 4'd15, ones));
      issue(mk(ACT_RECV, 3'd7, 8'h00, 4'd0, '0));
      issue(mk(ACT_SEND, 3'd0, 8'hFF, 4'd1, ones));
      issue(mk(ACT_SEND, 3'd3, 8'h00, 4'd8, ones));
      issue(mk(ACT_SEND, 3'd1, 8'hA5, 4'd5, {$urandom, $urandom}));
      issue(mk(ACT_RECV, 3'd0, 8'h00, 4'd0, '0));
      issue(mk(ACT_RECV, 3'd3, 8'h00, 4'd0, '0));
      issue(mk(ACT_SPARE, 3'd3, 8'hFF, 4'd15, ones));
      issue(mk(ACT_SEND, 3'd2, 8'h5A, 4'd3, ones));
      issue(mk(ACT_CLEAR, 3'd0, 8'h00, 4'd0, '0));
      issue(mk(ACT_RECV, 3'd2, 8'h00, 4'd0, '0));

      // Zero slots: everything refused, the node check still first.
      set_slots(5'd0);
      issue(mk(ACT_SEND, 3'd0, 8'h01, 4'd4, ones));
      issue(mk(ACT_RECV, 3'd0, 8'h00, 4'd0, '0));
      issue(mk(ACT_SEND, 3'd5, 8'h02, 4'd0, ones));

      // Single slot: fill, overflow, drain, underflow.
      set_slots(5'd1);
      issue(mk(ACT_SEND, 3'd0, 8'h03, 4'd2, {$urandom, $urandom}));
      issue(mk(ACT_SEND, 3'd0, 8'h04, 4'd2, ones));
      issue(mk(ACT_RECV, 3'd0, 8'h00, 4'd0, '0));
      issue(mk(ACT_RECV, 3'd0, 8'h00, 4'd0, '0));

      // Shrink the slot count while two messages wait: sends see a full
      // box and receives still drain, wrapping at the new count.
      set_slots(5'd3);
      issue(mk(ACT_SEND, 3'd1, 8'h05, 4'd6, {$urandom, $urandom}));
      issue(mk(ACT_SEND, 3'd1, 8'h06, 4'd7, {$urandom, $urandom}));
      set_slots(5'd1);
      issue(mk(ACT_SEND, 3'd1, 8'h07, 4'd1, ones));
      issue(mk(ACT_RECV, 3'd1, 8'h00, 4'd0, '0));
      issue(mk(ACT_RECV, 3'd1, 8'h00, 4'd0, '0));

      // Random phases, each at its own slot count; the setting changes with
      // messages still queued. The send share swings so boxes both fill up
      // and run dry. Every third phase runs without gaps.
      for (int p = 0; p < 10; p++) begin
         set_slots(SLOTS_W'(phase_slots[p]));
         calm     = (p % 3 == 1);
         send_pct = 50;
         for (int i = 0; i < phase_items[p]; i++) begin
            if (i % 40 == 0) send_pct = $urandom_range(85, 25);
            issue(random_command(send_pct));
            pause(calm ? 0 : random_gap());
         end
      end

      // Drain: hold start low until every owed reply has strobed, then let
      // the pipeline run a little longer to catch any stray strobe.
      pause(1);
      while (ledger.due_replies.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Run covered %0d commands under %0d slot-count writes.",
               ledger.commands, settings_written);
      $display("Messages delivered: %0d; sends refused on a full box: %0d.",
               ledger.delivered, ledger.refused_full);
      if (ledger.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: multi_node_mailbox_fifo.f
src/mnmb_pkg.sv
src/mnmb_csr.sv
src/mnmb_slot_mem.sv
src/mnmb_queue_ctrl.sv
src/multi_node_mailbox_fifo.sv
src/mnmb_checker.sv
tb/sv/multi_node_mailbox_fifo_test.sv
